FILE: hw/rtl/dsgb_pkg.sv
// Package for the scatter-gather list builder: sizes, codes, beat types
// and the command/status structs between controller and datapath.
// No dependencies.
package dsgb_pkg;

  // Sizing
  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
  localparam int MAX_SEGMENTS = 64;
  localparam int ADDR_BITS    = 32;
  localparam int LEN_W        = 13;   // piece length field
  localparam int CNT_W        = 7;    // segment count / number field
  localparam int DATA_W       = 32;   // config data and 32-bit result fields
  localparam int ROOM_W       = PAGE_BITS + 1;
  localparam int CLIP_W       = (ROOM_W > LEN_W) ? ROOM_W : LEN_W;
  localparam int BOUND_FLOOR  = (PAGE_BYTES / 16 > 256) ? PAGE_BYTES / 16 : 256;
  localparam int CFG_IDX_W    = 3;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUNDARY    = 3'd0,
    CFG_MAX_SEG_LEN = 3'd1,
    CFG_BOUNCE_LIM  = 3'd2,
    CFG_SEG_LIMIT   = 3'd3,
    CFG_MAP_SIZE    = 3'd4,
    CFG_BUS_OFFSET  = 3'd5
  } cfg_idx_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BOUNCE    = 2'd1,
    STAT_SEG_LIMIT = 2'd2,
    STAT_MAP_SIZE  = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CALC,
    S_MERGE,
    S_FINAL
  } state_t;

  // Input beat
  typedef struct packed {
    logic [ADDR_BITS-1:0] phys_addr;
    logic [LEN_W-1:0]     piece_len;
    logic                 first_of_map;
    logic                 last_of_map;
  } piece_t;

  // Output beat
  typedef struct packed {
    logic [ADDR_BITS-1:0] seg_addr;
    logic [DATA_W-1:0]    seg_len;
    logic [CNT_W-1:0]     segment_number;
    logic                 is_last;
    status_t              status;
    logic [DATA_W-1:0]    mapped_len;
  } seg_t;

  // Decoded configuration
  typedef struct packed {
    logic                 bnd_on;
    logic [ADDR_BITS-1:0] bnd;
    logic [ADDR_BITS-1:0] bnd_mask;
    logic [DATA_W-1:0]    max_seg_len;
    logic [DATA_W-1:0]    bounce_limit;
    logic [CNT_W-1:0]     seg_lim;
    logic [DATA_W-1:0]    map_size_limit;
    logic [ADDR_BITS-1:0] bus_offset;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic check;
    logic calc;
    logic merge;
    logic final_emit;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic err_set;
    logic over_size;
    logic rem_zero;
    logic bounce;
    logic join_seg;
    logic seg_full;
    logic seg_open;
    logic rem_done;
    logic last;
    logic out_free;
  } stat_t;

endpackage

FILE: hw/rtl/dsgb_cfg.sv
// Configuration registers of the scatter-gather list builder.
// Decodes boundary and segment limit at write time. Depends on dsgb_pkg.
module dsgb_cfg import dsgb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  // Effective boundary: highest set bit, raised to the floor
  function automatic logic [ADDR_BITS-1:0] eff_bound(input logic [DATA_W-1:0] v);
    logic [ADDR_BITS-1:0] top;
    top = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (v[i] && i < ADDR_BITS) top = ADDR_BITS'(1) << i;
    end
    if (top < ADDR_BITS'(BOUND_FLOOR)) top = ADDR_BITS'(BOUND_FLOOR);
    return top;
  endfunction

  // Segment limit clamped to 1..MAX_SEGMENTS
  function automatic logic [CNT_W-1:0] clamp_lim(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(MAX_SEGMENTS)) r = CNT_W'(MAX_SEGMENTS);
    return r;
  endfunction

  logic [ADDR_BITS-1:0] eb;

  assign cfg_ready = 1'b1;
  assign eb        = eff_bound(cfg_data);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bnd_on         <= 1'b0;
      cfg.bnd            <= '0;
      cfg.bnd_mask       <= '0;
      cfg.max_seg_len    <= DATA_W'(65536);
      cfg.bounce_limit   <= '0;
      cfg.seg_lim        <= CNT_W'(MAX_SEGMENTS);
      cfg.map_size_limit <= '1;
      cfg.bus_offset     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BOUNDARY: begin
          cfg.bnd_on   <= (cfg_data != '0);
          cfg.bnd      <= eb;
          cfg.bnd_mask <= ~(eb - ADDR_BITS'(1));
        end
        CFG_MAX_SEG_LEN: cfg.max_seg_len    <= cfg_data;
        CFG_BOUNCE_LIM:  cfg.bounce_limit   <= cfg_data;
        CFG_SEG_LIMIT:   cfg.seg_lim        <= clamp_lim(cfg_data[CNT_W-1:0]);
        CFG_MAP_SIZE:    cfg.map_size_limit <= cfg_data;
        CFG_BUS_OFFSET:  cfg.bus_offset     <= cfg_data[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/dsgb_ctrl.sv
// Controller state machine of the scatter-gather list builder.
// Sequences load, size check, chunk steps and final beat. Depends on dsgb_pkg.
module dsgb_ctrl import dsgb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  stat_t  st,
  output cmd_t   cmd,
  output state_t state
);

  state_t state_next;
  state_t done_state;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Where a piece goes once its chunks are done
  assign done_state = st.last ? S_FINAL : S_IDLE;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (st.err_set || st.over_size || st.rem_zero) state_next = done_state;
        else                                           state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        // stall only when a closed segment must go out and the slot is busy
        if (st.bounce || st.join_seg || st.seg_full || !st.seg_open || st.out_free) begin
          cmd.merge = 1'b1;
          if (st.bounce || (!st.join_seg && st.seg_full) || st.rem_done)
            state_next = done_state;
          else
            state_next = S_CALC;
        end
      end
      S_FINAL: begin
        if (st.out_free) begin
          cmd.final_emit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/dsgb_dpath.sv
// Datapath of the scatter-gather list builder: piece registers, open
// segment, map totals and the output register. Depends on dsgb_pkg.
module dsgb_dpath import dsgb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  piece_t in_data,
  input  cfg_t   cfg,
  input  cmd_t   cmd,
  output stat_t  st,
  output logic   out_valid,
  input  logic   out_ready,
  output seg_t   out_data
);

  // Piece work registers
  logic [ADDR_BITS-1:0] cur;
  logic [LEN_W-1:0]     rem;
  logic                 last;
  logic [LEN_W-1:0]     chunk;
  logic [ADDR_BITS-1:0] bus;
  logic                 bounce;

  // Map state
  logic [ADDR_BITS-1:0] open_addr;
  logic [DATA_W-1:0]    open_len;
  logic [ADDR_BITS-1:0] last_end;
  logic [CNT_W-1:0]     seg_count;
  logic [DATA_W-1:0]    total;
  status_t              err;

  // Load-time clip to the page
  logic [ROOM_W-1:0]    room;
  logic [LEN_W-1:0]     clip_len;

  assign room     = ROOM_W'(PAGE_BYTES) - ROOM_W'(in_data.phys_addr[PAGE_BITS-1:0]);
  assign clip_len = (CLIP_W'(in_data.piece_len) > CLIP_W'(room)) ?
                    LEN_W'(room) : in_data.piece_len;

  // Chunk length up to the next boundary
  logic [ADDR_BITS-1:0] bnd_gap;
  logic [LEN_W-1:0]     chunk_calc;

  assign bnd_gap    = ((cur + cfg.bnd) & cfg.bnd_mask) - cur;
  assign chunk_calc = (cfg.bnd_on && bnd_gap != '0 && bnd_gap < ADDR_BITS'(rem)) ?
                      LEN_W'(bnd_gap) : rem;

  // Merge decision
  logic [DATA_W:0] grown_len;
  logic            same_win;

  assign grown_len = {1'b0, open_len} + (DATA_W+1)'(chunk);
  assign same_win  = !cfg.bnd_on || ((open_addr & cfg.bnd_mask) == (bus & cfg.bnd_mask));

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // Status to the controller
  assign st.err_set   = (err != STAT_OK);
  assign st.over_size = ({1'b0, total} + (DATA_W+1)'(rem)) > {1'b0, cfg.map_size_limit};
  assign st.rem_zero  = (rem == '0);
  assign st.bounce    = bounce;
  assign st.join_seg  = (seg_count != '0) && (cur == last_end) &&
                        (grown_len <= {1'b0, cfg.max_seg_len}) && same_win;
  assign st.seg_full  = ({1'b0, seg_count} + (CNT_W+1)'(1)) > {1'b0, cfg.seg_lim};
  assign st.seg_open  = (seg_count != '0);
  assign st.rem_done  = (chunk == rem);
  assign st.last      = last;
  assign st.out_free  = out_free;

  // Piece registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur  <= in_data.phys_addr;
      rem  <= clip_len;
      last <= in_data.last_of_map;
    end else if (cmd.merge && !bounce && (st.join_seg || !st.seg_full)) begin
      cur <= cur + ADDR_BITS'(chunk);
      rem <= rem - chunk;
    end
    if (cmd.calc) begin
      chunk  <= chunk_calc;
      bus    <= cur + cfg.bus_offset;
      bounce <= (cfg.bounce_limit != '0) && (cur >= cfg.bounce_limit);
    end
  end

  // Map state
  always_ff @(posedge clk) begin
    if (rst || (cmd.load && in_data.first_of_map) || cmd.final_emit) begin
      open_addr <= '0;
      open_len  <= '0;
      last_end  <= '0;
      seg_count <= '0;
      total     <= '0;
      err       <= STAT_OK;
    end else if (cmd.check) begin
      if (err == STAT_OK) begin
        if (st.over_size) err   <= STAT_MAP_SIZE;
        else              total <= total + DATA_W'(rem);
      end
    end else if (cmd.merge) begin
      if (bounce) begin
        err <= STAT_BOUNCE;
      end else if (st.join_seg) begin
        open_len <= grown_len[DATA_W-1:0];
        last_end <= cur + ADDR_BITS'(chunk);
      end else if (st.seg_full) begin
        err <= STAT_SEG_LIMIT;
      end else begin
        open_addr <= bus;
        open_len  <= DATA_W'(chunk);
        seg_count <= seg_count + CNT_W'(1);
        last_end  <= cur + ADDR_BITS'(chunk);
      end
    end
  end

  // Output register: closed segment or final beat
  logic emit_closed;
  assign emit_closed = cmd.merge && !bounce && !st.join_seg && !st.seg_full &&
                       (seg_count != '0);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit_closed || cmd.final_emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_closed) begin
      out_data.seg_addr       <= open_addr;
      out_data.seg_len        <= open_len;
      out_data.segment_number <= seg_count - CNT_W'(1);
      out_data.is_last        <= 1'b0;
      out_data.status         <= STAT_OK;
      out_data.mapped_len     <= '0;
    end else if (cmd.final_emit) begin
      out_data.is_last <= 1'b1;
      out_data.status  <= err;
      if (err != STAT_OK) begin
        out_data.seg_addr       <= '0;
        out_data.seg_len        <= '0;
        out_data.segment_number <= '0;
        out_data.mapped_len     <= '0;
      end else begin
        out_data.seg_addr       <= open_addr;
        out_data.seg_len        <= open_len;
        out_data.segment_number <= seg_count;
        out_data.mapped_len     <= total;
      end
    end
  end

endmodule

FILE: hw/rtl/dma_scatter_gather_builder.sv
// Scatter-gather list builder, top level. Takes one page-contained piece per
// input beat and emits closed segments and a final status beat per map.
// Depends on dsgb_pkg, dsgb_cfg, dsgb_ctrl, dsgb_dpath.
//
// One piece at a time: a piece is loaded and size-checked, then each boundary
// chunk is cut in S_CALC and merged or opens a segment in S_MERGE, and the
// final beat follows in S_FINAL when the piece ends the map; a piece of
// 4096 bytes with a 256-byte boundary is at most 16 chunks. The controller
// stalls only while a finished beat waits in the single output register and
// the next one is due. After an error, pieces are only loaded and size-checked
// until the one that ends the map. Configuration writes are taken every
// cycle and must only happen while the block is idle.
module dma_scatter_gather_builder import dsgb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  piece_t               in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output seg_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cfg_t   cfg;
  cmd_t   cmd;
  stat_t  st;
  state_t state;

  dsgb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dsgb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd),
    .state    (state)
  );

  dsgb_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An accepted piece always goes on to the size check
  a_load_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted piece did not reach size check");

  // A closed segment never carries a number at or past the segment limit
  a_seg_num: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.is_last) |-> (out_data.segment_number < cfg.seg_lim))
    else $error("closed segment number beyond limit");

  // Error status only appears on a final beat
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != STAT_OK) |-> out_data.is_last)
    else $error("error status on a non-final beat");

  // A new beat is loaded only into a free output slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.final_emit || (cmd.merge && !st.bounce && !st.join_seg && !st.seg_full &&
      st.seg_open)) |-> (!out_valid || out_ready))
    else $error("output beat overwritten");

endmodule
